@@ design/graph_reachability_tree_check_defines.svh @@
// Assertion macros shared by the graph reachability block.
`ifndef GRAPH_REACHABILITY_TREE_CHECK_DEFINES_SVH
`define GRAPH_REACHABILITY_TREE_CHECK_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("graph reachability check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("graph reachability check failed");

`endif

@@ design/grc_pkg.sv @@
// Package with sizes, codes and shared types of the graph reachability block.
`timescale 1ns / 1ps
package grc_pkg;

   localparam int MAX_VERTICES    = 64;
   localparam int EDGE_COUNT_BITS = 12;
   localparam int VIDX_BITS       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NCNT_BITS       = $clog2(MAX_VERTICES + 1);
   localparam int MODE_BITS       = 3;
   localparam int VNUM_BITS       = 9;
   localparam int VC_BITS         = 7;
   localparam int FIRST_BITS      = 8;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_VERTEX = CSR_INDEX_BITS'(1);

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [VIDX_BITS-1:0]    vidx_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD_UNDIR = 3'd0,
      MODE_ADD_DIR   = 3'd1,
      MODE_PATH      = 3'd2,
      MODE_TREE      = 3'd3,
      MODE_CLEAR     = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INS_FWD,
      ST_INS_REV,
      ST_WALK
   } state_type;

   // Active configuration as the controller sees it.
   typedef struct packed {
      logic [NCNT_BITS-1:0]  n_used;
      logic [FIRST_BITS-1:0] first;
   } cfg_type;

   // One cycle of requests to the adjacency memory.
   typedef struct packed {
      logic     clear;
      logic     rd_en;
      vidx_type rd_addr;
      logic     wr_en;
      vidx_type wr_addr;
      row_type  wr_bits;
   } mem_req_type;

endpackage

@@ design/grc_adj_mem.sv @@
// Adjacency row memory with per-row valid bits and bit-enable writes.
`timescale 1ns / 1ps
module grc_adj_mem
   import grc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output row_type     rd_data
);

   row_type mem [MAX_VERTICES];
   row_type row_valid_ff;
   row_type rd_q_ff;
   logic    rd_valid_ff;

   // A row that was never written since reset or clear reads as empty.
   always_ff @(posedge clock) begin
      if (reset || mem_req.clear) begin
         row_valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         row_valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   // Stale rows are overwritten whole; live rows only take the new bits.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            if (!row_valid_ff[mem_req.wr_addr] || mem_req.wr_bits[i]) begin
               mem[mem_req.wr_addr][i] <= mem_req.wr_bits[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_q_ff     <= mem[mem_req.rd_addr];
         rd_valid_ff <= row_valid_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

@@ design/grc_ctrl.sv @@
// Item sequencer: range checks, edge inserts, frontier walk and results.
`timescale 1ns / 1ps
module grc_ctrl
   import grc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 start,
   output logic                 busy,
   input  logic [MODE_BITS-1:0] req_mode,
   input  logic [VNUM_BITS-1:0] req_from_vertex,
   input  logic [VNUM_BITS-1:0] req_to_vertex,
   output logic                 rsp_valid,
   output logic                 rsp_answer,
   output logic                 rsp_status,
   output mem_req_type          mem_req,
   input  row_type              rd_data
);

   state_type                  state_ff, state_in;
   vidx_type                   a_ff, a_in, b_ff, b_in;
   logic                       dir_ff, dir_in;
   logic                       path_ff, path_in;
   row_type                    visited_ff, visited_in;
   row_type                    frontier_ff, frontier_in;
   logic                       inflight_ff, inflight_in;
   logic [EDGE_COUNT_BITS-1:0] count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_answer_ff, rsp_answer_in;
   logic                       rsp_status_ff, rsp_status_in;

   row_type              vmask;
   row_type              fresh;
   row_type              lowbit;
   vidx_type             pick;
   vidx_type             a_idx, b_idx;
   logic                 a_ok, b_ok;
   logic [VNUM_BITS-1:0] a_diff, b_diff;
   mode_type             mode;

   assign mode = mode_type'(req_mode);

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         vmask[i] = (i < int'(cfg.n_used));
      end
   end

   // External numbers become indexes relative to the first vertex number.
   always_comb begin
      a_diff = req_from_vertex - VNUM_BITS'(cfg.first);
      b_diff = req_to_vertex - VNUM_BITS'(cfg.first);
      a_ok   = (req_from_vertex >= VNUM_BITS'(cfg.first)) && (int'(a_diff) < int'(cfg.n_used));
      b_ok   = (req_to_vertex >= VNUM_BITS'(cfg.first)) && (int'(b_diff) < int'(cfg.n_used));
      a_idx  = a_diff[VIDX_BITS-1:0];
      b_idx  = b_diff[VIDX_BITS-1:0];
   end

   // Lowest pending frontier vertex.
   always_comb begin
      lowbit = frontier_ff & (~frontier_ff + row_type'(1));
      pick   = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (lowbit[i]) begin
            pick = pick | VIDX_BITS'(i);
         end
      end
   end

   assign fresh = rd_data & vmask & ~visited_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      dir_ff        <= dir_in;
      path_ff       <= path_in;
      visited_ff    <= visited_in;
      frontier_ff   <= frontier_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      dir_in        = dir_ff;
      path_in       = path_ff;
      visited_in    = visited_ff;
      frontier_in   = frontier_ff;
      inflight_in   = 1'b0;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_answer_in = 1'b0;
      rsp_status_in = 1'b0;
      mem_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in = a_idx;
               b_in = b_idx;
               if ((mode inside {MODE_ADD_UNDIR, MODE_ADD_DIR, MODE_PATH}) && !(a_ok && b_ok)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = 1'b1;
               end else begin
                  case (mode)
                     MODE_ADD_UNDIR, MODE_ADD_DIR: begin
                        dir_in   = (mode == MODE_ADD_DIR);
                        state_in = ST_INS_FWD;
                     end
                     MODE_PATH: begin
                        path_in     = 1'b1;
                        visited_in  = row_type'(1) << a_idx;
                        frontier_in = row_type'(1) << a_idx;
                        state_in    = ST_WALK;
                     end
                     MODE_TREE: begin
                        path_in     = 1'b0;
                        visited_in  = row_type'(1);
                        frontier_in = row_type'(1);
                        state_in    = ST_WALK;
                     end
                     MODE_CLEAR: begin
                        mem_req.clear = 1'b1;
                        count_in      = '0;
                        visited_in    = '0;
                        frontier_in   = '0;
                        rsp_valid_in  = 1'b1;
                     end
                     default: begin
                        rsp_valid_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_INS_FWD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = a_ff;
            mem_req.wr_bits = row_type'(1) << b_ff;
            if (dir_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_INS_REV;
            end
         end
         ST_INS_REV: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = b_ff;
            mem_req.wr_bits = row_type'(1) << a_ff;
            if (count_ff != '1) begin
               count_in = count_ff + EDGE_COUNT_BITS'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_WALK: begin
            // Issue one row read a cycle and merge the row that returns.
            if (inflight_ff) begin
               visited_in = visited_ff | fresh;
            end
            if (frontier_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pick;
               inflight_in     = 1'b1;
            end
            frontier_in = (frontier_ff & ~lowbit) | (inflight_ff ? fresh : '0);
            if ((frontier_ff == '0) && !inflight_ff) begin
               rsp_valid_in = 1'b1;
               if (path_ff) begin
                  rsp_answer_in = visited_ff[b_ff];
               end else begin
                  rsp_answer_in = ((visited_ff & vmask) == vmask)
                                  && (int'(count_ff) == int'(cfg.n_used) - 1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ design/graph_reachability_tree_check.sv @@
// Top level of the graph reachability and tree check block.
`timescale 1ns / 1ps
`include "graph_reachability_tree_check_defines.svh"
// The block keeps a graph of up to MAX_VERTICES vertices as adjacency rows in
// a synchronous memory, plus a saturating count of undirected edges inserted.
// An item beat is taken at a rising edge where start is high and busy is low;
// it carries a mode (add undirected edge, add directed edge, path query, tree
// query, clear) and two external vertex numbers. Every item yields one result
// beat: rsp_valid is high for exactly one cycle with rsp_answer and
// rsp_status; the receiver cannot stall it. Clear, unused modes and add or
// path items with a vertex number outside the configured range answer in
// the next cycle. A directed insert writes the row of its from vertex and an
// undirected insert also the row of its to vertex, one memory write per row.
// A query walks the frontier, reading one adjacency row per cycle from the
// single memory read port. The configuration beat (csr_valid, csr_ready,
// csr_index, csr_wdata) sets the vertex count and the first vertex number;
// it is always ready, and the user must write it only while the block is
// idle; the block itself does not enforce this. Reset empties the graph at
// once through per-row valid bits and sets the vertex count to 1 and the
// first vertex number to 0; there is no clearing pass.
module graph_reachability_tree_check
   import grc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [MODE_BITS-1:0]      req_mode,
   input  logic [VNUM_BITS-1:0]      req_from_vertex,
   input  logic [VNUM_BITS-1:0]      req_to_vertex,
   output logic                      rsp_valid,
   output logic                      rsp_answer,
   output logic                      rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [VC_BITS-1:0]    vertex_count_ff;
   logic [FIRST_BITS-1:0] first_vertex_ff;
   logic [NCNT_BITS-1:0]  n_used;
   cfg_type               cfg;
   mem_req_type           mem_req;
   row_type               rd_data;

   assign csr_ready = 1'b1;

   // Configuration registers; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VC_BITS'(1);
         first_vertex_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[VC_BITS-1:0];
            CSR_FIRST_VERTEX: first_vertex_ff <= csr_wdata[FIRST_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // A vertex count of zero acts as one; counts above the capacity are capped.
   always_comb begin
      if (vertex_count_ff == '0) begin
         n_used = NCNT_BITS'(1);
      end else if (int'(vertex_count_ff) > MAX_VERTICES) begin
         n_used = NCNT_BITS'(MAX_VERTICES);
      end else begin
         n_used = NCNT_BITS'(vertex_count_ff);
      end
      cfg.n_used = n_used;
      cfg.first  = first_vertex_ff;
   end

   grc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_answer      (rsp_answer),
      .rsp_status      (rsp_status),
      .mem_req         (mem_req),
      .rd_data         (rd_data)
   );

   grc_adj_mem u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // An accepted item either answers in the next cycle or keeps the block busy.
   `GRC_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)
   // Leaving a multi-cycle item always delivers its result beat.
   `GRC_ASSERT_NOW(a_busy_end_result, clock, reset, $fell(busy) && !$past(reset), rsp_valid)
   // A rejected vertex number never comes with a positive answer.
   `GRC_ASSERT_NOW(a_reject_no_answer, clock, reset, rsp_valid && rsp_status, !rsp_answer)

endmodule

@@ sim/grc_result_monitor.sv @@
// Monitor that predicts and checks every result beat of the graph reachability block.
`timescale 1ns / 1ps
module grc_result_monitor
   import grc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [MODE_BITS-1:0]      req_mode,
   input  logic [VNUM_BITS-1:0]      req_from_vertex,
   input  logic [VNUM_BITS-1:0]      req_to_vertex,
   input  logic                      rsp_valid,
   input  logic                      rsp_answer,
   input  logic                      rsp_status,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatch_count,
   output int                        results_pending
);

   typedef struct packed {
      logic answer;
      logic status;
   } reply_type;

   row_type                    graph_rows [MAX_VERTICES];
   logic [EDGE_COUNT_BITS-1:0] undirected_total;
   logic [VC_BITS-1:0]         vertex_count_reg;
   logic [FIRST_BITS-1:0]      first_number_reg;
   reply_type                  replies_due [$];
   int                         mismatch_total = 0;
   int                         result_beats = 0;

   assign mismatch_count = mismatch_total;

   task automatic report_mismatch(input string note);
      $display("[%0t] result beat %0d: %s", $time, result_beats, note);
      mismatch_total++;
   endtask

   function automatic void wipe_graph();
      int unsigned v;
      for (v = 0; v < MAX_VERTICES; v++) graph_rows[v] = '0;
      undirected_total = '0;
   endfunction

   // A vertex count of zero acts as one; counts above the array size are clamped.
   function automatic int unsigned vertices_in_use();
      if (vertex_count_reg == '0) return 1;
      if (int'(vertex_count_reg) > MAX_VERTICES) return MAX_VERTICES;
      return 32'(vertex_count_reg);
   endfunction

   function automatic row_type use_mask(input int unsigned n);
      row_type     mask;
      int unsigned v;
      mask = '0;
      for (v = 0; v < n; v++) mask[v] = 1'b1;
      return mask;
   endfunction

   // Breadth-first walk: each round ORs the rows of the current wave and keeps the
   // vertices in use that were not reached before.
   function automatic row_type reach_set(input int unsigned source, input int unsigned n);
      row_type     visited;
      row_type     wave;
      row_type     grown;
      int unsigned v;
      visited         = '0;
      visited[source] = 1'b1;
      wave            = visited;
      while (wave != '0) begin
         grown = '0;
         for (v = 0; v < n; v++)
            if (wave[v]) grown |= graph_rows[v];
         grown   &= ~visited & use_mask(n);
         visited |= grown;
         wave     = grown;
      end
      return visited;
   endfunction

   function automatic reply_type resolve_request(input logic [MODE_BITS-1:0] mode_bits,
                                                 input logic [VNUM_BITS-1:0] from_number,
                                                 input logic [VNUM_BITS-1:0] to_number);
      mode_type    mode;
      int unsigned n;
      int          from_idx;
      int          to_idx;
      bit          in_range;
      reply_type   reply;
      row_type     reached;
      mode     = mode_type'(mode_bits);
      n        = vertices_in_use();
      from_idx = int'(from_number) - int'(first_number_reg);
      to_idx   = int'(to_number) - int'(first_number_reg);
      in_range = from_idx >= 0 && from_idx < int'(n) && to_idx >= 0 && to_idx < int'(n);
      reply    = '0;
      if ((mode == MODE_ADD_UNDIR || mode == MODE_ADD_DIR || mode == MODE_PATH)
          && !in_range) begin
         reply.status = 1'b1;
         return reply;
      end
      case (mode)
         MODE_ADD_UNDIR: begin
            graph_rows[from_idx][to_idx] = 1'b1;
            graph_rows[to_idx][from_idx] = 1'b1;
            if (undirected_total != '1) undirected_total++;
         end
         MODE_ADD_DIR: begin
            graph_rows[from_idx][to_idx] = 1'b1;
         end
         MODE_PATH: begin
            reached      = reach_set(from_idx, n);
            reply.answer = reached[to_idx];
         end
         MODE_TREE: begin
            reached      = reach_set(0, n);
            reply.answer = (reached == use_mask(n)) && (32'(undirected_total) == n - 1);
         end
         MODE_CLEAR: begin
            wipe_graph();
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type due;
      if (reset) begin
         wipe_graph();
         vertex_count_reg = VC_BITS'(1);
         first_number_reg = '0;
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("no request waiting (answer %0b status %0b)",
                                         rsp_answer, rsp_status));
            end else begin
               due = replies_due.pop_front();
               if (rsp_answer !== due.answer)
                  report_mismatch($sformatf("answer %0b, expected %0b",
                                            rsp_answer, due.answer));
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status %0b, expected %0b",
                                            rsp_status, due.status));
            end
            result_beats++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VERTEX_COUNT)
               vertex_count_reg = csr_wdata[VC_BITS-1:0];
            else if (csr_index == CSR_FIRST_VERTEX)
               first_number_reg = csr_wdata[FIRST_BITS-1:0];
         end
         if (start && !busy)
            replies_due.push_back(resolve_request(req_mode, req_from_vertex, req_to_vertex));
      end
      results_pending <= replies_due.size();
   end

endmodule

@@ sim/graph_reachability_tree_check_test.sv @@
// Top of the graph reachability testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module graph_reachability_tree_check_test;
   import grc_pkg::*;

   // Mode codes the block does not define; they must answer 0 with status 0.
   localparam logic [MODE_BITS-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_C = 3'd7;
   // A register index with no register behind it; a write there must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = CSR_INDEX_BITS'(7);

   localparam int unsigned VNUM_TOP    = (1 << VNUM_BITS) - 1;
   localparam int unsigned ITEM_TARGET = 400;
   // Past this many item beats the sender no longer idles.
   localparam int unsigned QUIET_AFTER = 330;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      start           = 1'b0;
   logic                      busy;
   logic [MODE_BITS-1:0]      req_mode        = '0;
   logic [VNUM_BITS-1:0]      req_from_vertex = '0;
   logic [VNUM_BITS-1:0]      req_to_vertex   = '0;
   logic                      rsp_valid;
   logic                      rsp_answer;
   logic                      rsp_status;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index       = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata       = '0;
   int                        mismatch_count;
   int                        results_pending;

   // What the stimulus believes the configuration to be, used to aim vertex numbers.
   int unsigned vertices_now = 1;
   int unsigned first_now    = 0;
   int unsigned items_sent   = 0;
   bit          gaps_enabled = 1'b1;

   graph_reachability_tree_check dut (.*);

   grc_result_monitor monitor (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Drives one item beat and returns at the edge that accepts it. Start is left
   // high so that back-to-back beats never lower and raise it in one step; an
   // idle burst, when one is drawn, drops it only after the acceptance.
   task automatic send_item(input logic [MODE_BITS-1:0] mode,
                            input int unsigned from_number,
                            input int unsigned to_number);
      start           <= 1'b1;
      req_mode        <= mode;
      req_from_vertex <= VNUM_BITS'(from_number);
      req_to_vertex   <= VNUM_BITS'(to_number);
      do @(posedge clock); while (busy);
      items_sent++;
      if (gaps_enabled && items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Holds the sender off until every predicted result beat has come back and
   // the block has dropped busy.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_pending != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after its last write.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0]  data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Reprograms both registers while the block is idle. The vertex count field is
   // seven bits wide, so bit 7 of the write data is dropped before clamping.
   task automatic configure(input logic [CSR_DATA_BITS-1:0] count_code,
                            input logic [CSR_DATA_BITS-1:0] first_code);
      int unsigned count;
      settle();
      if ($urandom_range(0, 3) == 0) write_register(CSR_SPARE, CSR_DATA_BITS'($urandom));
      write_register(CSR_VERTEX_COUNT, count_code);
      write_register(CSR_FIRST_VERTEX, first_code);
      csr_valid <= 1'b0;
      @(posedge clock);
      count        = 32'(count_code[VC_BITS-1:0]);
      vertices_now = (count == 0) ? 1 : (count > MAX_VERTICES) ? MAX_VERTICES : count;
      first_now    = 32'(first_code);
   endtask

   function automatic int unsigned some_vertex();
      return first_now + $urandom_range(0, vertices_now - 1);
   endfunction

   // Picks a vertex number that is often just outside the configured range.
   function automatic int unsigned stray_vertex();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, VNUM_TOP);
         1: return first_now + vertices_now;
         2: return (first_now > 0) ? first_now - 1 : VNUM_TOP;
         default: return some_vertex();
      endcase
   endfunction

   // Noise: any mode code, including the undefined ones, with loosely aimed vertices.
   task automatic send_stray();
      send_item(MODE_BITS'($urandom_range(0, 7)), stray_vertex(), stray_vertex());
   endtask

   // One random phase: a fresh configuration, then mostly a random spanning tree
   // built edge by edge, probed with path and tree queries, then sometimes disturbed by
   // an extra edge; an extra undirected edge makes the tree test fail again.
   task automatic run_random_phase();
      int unsigned order [MAX_VERTICES];
      int unsigned count_code;
      int unsigned first_code;
      int unsigned pick;
      int unsigned swap;
      int unsigned held;
      int unsigned v;
      int unsigned a;
      int unsigned b;
      pick = $urandom_range(0, 19);
      if (pick == 0)      count_code = 0;
      else if (pick == 1) count_code = 8'hFF;
      else if (pick == 2) count_code = MAX_VERTICES;
      else if (pick <= 5) count_code = $urandom_range(13, MAX_VERTICES - 1);
      else                count_code = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      if (pick == 0)      first_code = 0;
      else if (pick == 1) first_code = 8'hFF;
      else                first_code = $urandom_range(0, 8'hFF);
      configure(CSR_DATA_BITS'(count_code), CSR_DATA_BITS'(first_code));
      gaps_enabled = ($urandom_range(0, 3) != 0);

      // Now and then the old graph is kept, so rows of vertices beyond the new
      // count stay in the array and must be ignored by walks.
      if ($urandom_range(0, 6) != 0) send_item(MODE_CLEAR, stray_vertex(), stray_vertex());

      for (v = 0; v < vertices_now; v++) order[v] = v;
      for (v = vertices_now - 1; v > 0; v--) begin
         swap        = $urandom_range(0, v);
         held        = order[v];
         order[v]    = order[swap];
         order[swap] = held;
      end

      for (v = 1; v < vertices_now; v++) begin
         a = first_now + order[v];
         b = first_now + order[$urandom_range(0, v - 1)];
         if ($urandom_range(0, 1)) send_item(MODE_ADD_UNDIR, a, b);
         else                      send_item(MODE_ADD_UNDIR, b, a);
         pick = $urandom_range(0, 19);
         if (pick < 4)       send_item(MODE_PATH, some_vertex(), some_vertex());
         else if (pick < 6)  send_item(MODE_TREE, stray_vertex(), stray_vertex());
         else if (pick == 6) send_stray();
      end

      send_item(MODE_TREE, stray_vertex(), stray_vertex());
      repeat ($urandom_range(1, 4)) send_item(MODE_PATH, some_vertex(), some_vertex());

      pick = $urandom_range(0, 3);
      if (pick == 0)      send_item(MODE_ADD_UNDIR, some_vertex(), some_vertex());
      else if (pick == 1) send_item(MODE_ADD_DIR, some_vertex(), some_vertex());
      send_item(MODE_TREE, stray_vertex(), stray_vertex());
      send_item(MODE_PATH, some_vertex(), some_vertex());
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_stray();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset there is one vertex, number 0, and no edges: that
      // single vertex is a tree, and it reaches itself.
      send_item(MODE_TREE, 0, 0);
      send_item(MODE_PATH, 0, 0);
      // Vertex 1 is past the one vertex in use, and 511 is the largest number.
      send_item(MODE_ADD_UNDIR, 0, 1);
      send_item(MODE_ADD_DIR, VNUM_TOP, 0);
      // Undefined mode codes do nothing.
      send_item(MODE_SPARE_A, VNUM_TOP, VNUM_TOP);
      send_item(MODE_SPARE_B, 0, VNUM_TOP);
      send_item(MODE_SPARE_C, VNUM_TOP, 0);
      // A self loop still counts as an undirected edge, so the tree test fails
      // until a clear empties the count again.
      send_item(MODE_ADD_UNDIR, 0, 0);
      send_item(MODE_TREE, 0, 0);
      send_item(MODE_CLEAR, VNUM_TOP, VNUM_TOP);
      send_item(MODE_TREE, VNUM_TOP, VNUM_TOP);

      // All write data bits set: the count field reads 127 and clamps to the
      // full array, and the first vertex number is at its top, 255, so valid
      // numbers run up to 318.
      configure(8'hFF, 8'hFF);
      send_item(MODE_ADD_UNDIR, 255, 318);
      send_item(MODE_ADD_DIR, 318, 256);
      send_item(MODE_PATH, 255, 256);
      send_item(MODE_PATH, 256, 255);
      // One below the first number, one past the last, and the largest number.
      send_item(MODE_ADD_UNDIR, 254, 300);
      send_item(MODE_ADD_DIR, 300, 319);
      send_item(MODE_PATH, VNUM_TOP, 255);
      // The tree query ignores its vertex fields altogether.
      send_item(MODE_TREE, VNUM_TOP, 0);

      // A count of zero acts as one vertex; the rows written above are kept but
      // ignored until the count is raised again.
      configure(8'h00, 8'hFF);
      send_item(MODE_PATH, 255, 255);
      send_item(MODE_TREE, 0, 0);
      send_item(MODE_ADD_UNDIR, 255, 256);
      configure(CSR_DATA_BITS'(MAX_VERTICES), 8'hFF);
      send_item(MODE_PATH, 255, 256);
      send_item(MODE_CLEAR, 0, 0);
      send_item(MODE_TREE, 0, 0);
      configure(8'd2, 8'd0);
      send_item(MODE_ADD_UNDIR, 1, 0);
      send_item(MODE_TREE, 0, 0);

      // Random phases; every reconfiguration first drains all results.
      while (items_sent < ITEM_TARGET) run_random_phase();

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("graph_reachability_tree_check verification clean");
      end else begin
         $display("graph_reachability_tree_check verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("graph_reachability_tree_check verification failed");
      $finish;
   end

endmodule
